@@ hw/rtl/idq_pkg.sv @@
// Shared types and constants for the indexed deque store.
// Holds field widths, operation and status codes, and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package idq_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND     = 3'd0,
    KIND_PREPEND    = 3'd1,
    KIND_INSERT     = 3'd2,
    KIND_READ_IDX   = 3'd3,
    KIND_READ_FIRST = 3'd4,
    KIND_READ_LAST  = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;       // capture input item
    logic eval;         // latch checked status
    logic shift_start;  // load shift pointer with count-1
    logic shift_rd;     // read element at shift pointer
    logic shift_wr;     // write it one place up, step pointer down
    logic item_rd;      // read element addressed by the item
    logic wr_value;     // store new element, bump count
    logic load_result;  // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic is_write;
    logic is_read;
    logic eval_ok;
    logic need_shift;   // some elements sit at or above the insert slot
    logic shift_last;   // shift pointer has reached the insert slot
  } sts_t;

endpackage : idq_pkg

`default_nettype wire

@@ hw/rtl/indexed_deque_store_unit.sv @@
// Indexed deque store: ordered store with append, prepend, insert at index and reads.
// Steps from input transfer to result valid: check, then result load for errors and
// unused kinds; reads add a memory read, writes a read and write per element moved up
// by the insert, then the element write. One item at a time, until its result is taken.
// Reset (async, active low) clears the fill count and output valid; memory is not cleared.
// Depends on idq_pkg, idq_ctrl and idq_datapath.
`timescale 1ns / 1ps
`default_nettype none

module indexed_deque_store_unit
  import idq_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [KIND_W-1:0]          kind_i,
  input  wire logic signed [VALUE_W-1:0]  value_i,
  input  wire logic [POS_W-1:0]           position_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [VALUE_W-1:0]       read_data_o,
  output logic [STATUS_W-1:0]             status_o,
  output logic [COUNT_W-1:0]              count_o
);

  // The controller walks each operation through check, optional shift loop,
  // memory access for a valid read or write, and result load. Inserts move
  // elements from the top down so no element is overwritten before it has
  // been copied one place up. A new item is taken only from idle and only
  // when the output register is empty or its transfer completes in that cycle.
  cmd_t cmd;
  sts_t sts;

  idq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  idq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

`ifndef SYNTHESIS
  // an accepted item keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transfer");

  // errors never carry data
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> read_data_o == '0)
    else $error("error result with nonzero data");

  // full is only reported when the store really holds CAPACITY elements
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> count_o == COUNT_W'(CAPACITY))
    else $error("full status with wrong count");
`endif

endmodule : indexed_deque_store_unit

`default_nettype wire

@@ hw/rtl/idq_ctrl.sv @@
// Sequencing state machine for the indexed deque store.
// Issues cmd_t to the datapath and reacts to its sts_t; uses idq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idq_ctrl
  import idq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SH_RD,
    S_SH_WR,
    S_WRITE,
    S_RD,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE) || !sts_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval        = 1'b1;
        cmd_o.shift_start = 1'b1;
        if (!sts_i.eval_ok || (!sts_i.is_write && !sts_i.is_read)) begin
          state_d = S_DONE;
        end else if (sts_i.is_write) begin
          state_d = sts_i.need_shift ? S_SH_RD : S_WRITE;
        end else begin
          state_d = S_RD;
        end
      end
      S_SH_RD: begin
        cmd_o.shift_rd = 1'b1;
        state_d        = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = sts_i.shift_last ? S_WRITE : S_SH_RD;
      end
      S_WRITE: begin
        cmd_o.wr_value = 1'b1;
        state_d        = S_DONE;
      end
      S_RD: begin
        cmd_o.item_rd = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        cmd_o.load_result = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : idq_ctrl

`default_nettype wire

@@ hw/rtl/idq_datapath.sv @@
// Datapath of the indexed deque store: element memory, fill count,
// item registers, shift pointer and output register. Uses idq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idq_datapath
  import idq_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cmd_t                       cmd_i,
  output sts_t                            sts_o,
  input  wire logic [KIND_W-1:0]          kind_i,
  input  wire logic signed [VALUE_W-1:0]  value_i,
  input  wire logic [POS_W-1:0]           position_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [VALUE_W-1:0]       read_data_o,
  output logic [STATUS_W-1:0]             status_o,
  output logic [COUNT_W-1:0]              count_o
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic [CW-1:0]          count_q;
  logic [KIND_W-1:0]      kind_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]       pos_q;
  logic [AW-1:0]          ptr_q;
  status_e                status_q;

  logic                   out_valid_q;
  logic signed [VALUE_W-1:0] res_data_q;
  status_e                res_status_q;
  logic [COUNT_W-1:0]     res_count_q;

  logic [CMPW-1:0] pos_x, count_x, at_x;
  logic [AW-1:0]   at, item_addr, rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data, store_val;
  logic [63:0]     val_sx, rd_zx;
  logic            is_write, is_read, full;
  status_e         eval_status;

  assign pos_x   = CMPW'(pos_q);
  assign count_x = CMPW'(count_q);
  assign full    = (count_q == CW'(CAPACITY));

  // element to store: sign-extended input kept to the storage width
  assign val_sx    = {{(64 - VALUE_W){value_q[VALUE_W-1]}}, value_q};
  assign store_val = val_sx[DATA_WIDTH-1:0];
  assign rd_zx     = 64'(rdata_q);

  always_comb begin
    is_write    = 1'b0;
    is_read     = 1'b0;
    eval_status = ST_OK;
    at_x        = count_x;
    item_addr   = '0;
    case (kind_q)
      KIND_APPEND: begin
        is_write    = 1'b1;
        at_x        = count_x;
        eval_status = full ? ST_FULL : ST_OK;
      end
      KIND_PREPEND: begin
        is_write    = 1'b1;
        at_x        = '0;
        eval_status = full ? ST_FULL : ST_OK;
      end
      KIND_INSERT: begin
        is_write = 1'b1;
        at_x     = pos_x;
        if (pos_x > count_x) begin
          eval_status = ST_RANGE;
        end else if (full) begin
          eval_status = ST_FULL;
        end
      end
      KIND_READ_IDX: begin
        is_read     = 1'b1;
        item_addr   = AW'(pos_q);
        eval_status = (pos_x >= count_x) ? ST_RANGE : ST_OK;
      end
      KIND_READ_FIRST: begin
        is_read     = 1'b1;
        item_addr   = '0;
        eval_status = (count_q == '0) ? ST_EMPTY : ST_OK;
      end
      KIND_READ_LAST: begin
        is_read     = 1'b1;
        item_addr   = AW'(count_q - 1'b1);
        eval_status = (count_q == '0) ? ST_EMPTY : ST_OK;
      end
      default: begin
        eval_status = ST_OK;
      end
    endcase
  end

  assign at = AW'(at_x);

  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.is_write   = is_write;
  assign sts_o.is_read    = is_read;
  assign sts_o.eval_ok    = (eval_status == ST_OK);
  assign sts_o.need_shift = (at_x < count_x);
  assign sts_o.shift_last = (ptr_q == at);

  // single write port: shift move or new element
  assign rd_addr = cmd_i.shift_rd ? ptr_q : item_addr;
  assign wr_addr = cmd_i.shift_wr ? AW'(ptr_q + 1'b1) : at;
  assign wr_data = cmd_i.shift_wr ? rdata_q : store_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_wr || cmd_i.wr_value) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.shift_rd || cmd_i.item_rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
    if (cmd_i.eval) begin
      status_q <= eval_status;
    end
    if (cmd_i.shift_start) begin
      ptr_q <= AW'(count_q - 1'b1);
    end else if (cmd_i.shift_wr) begin
      ptr_q <= ptr_q - 1'b1;
    end
    if (cmd_i.load_result) begin
      res_status_q <= status_q;
      res_count_q  <= COUNT_W'(count_q);
      res_data_q   <= (is_read && status_q == ST_OK) ? rd_zx[VALUE_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_value) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = res_data_q;
  assign status_o    = res_status_q;
  assign count_o     = res_count_q;

endmodule : idq_datapath

`default_nettype wire

@@ test/indexed_deque_store_unit_test.sv @@
// Self-checking testbench for indexed_deque_store_unit: directed and random deque operations
// with a predictor of the store's contents and count. Depends on idq_pkg and the RTL only.
`timescale 1ns / 1ps

module indexed_deque_store_unit_test;
  import idq_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int RANDOM_PER_PHASE = 407;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 30;
  localparam int PRINT_CAP = 100;

  // kinds outside the enum; the block must answer them with ok and the unchanged count
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } deque_op_t;

  typedef struct {
    logic [VALUE_W-1:0] read_data;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } deque_answer_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [KIND_W-1:0]   kind_i = '0;
  logic [VALUE_W-1:0]  value_i = '0;
  logic [POS_W-1:0]    position_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [VALUE_W-1:0]  read_data_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  count_o;

  // Items waiting to be driven, and answers waiting on the result channel (oldest first).
  deque_op_t     op_queue[$];
  deque_answer_t awaited_answers[$];

  // Predictor state: logical order of the stored elements and their number.
  logic [VALUE_W-1:0] model_elems[STORE_DEPTH];
  int unsigned        model_count = 0;

  // Count as the stimulus generator expects it, used to aim positions at the live range.
  int unsigned plan_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  indexed_deque_store_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one operation to the predicted store and return the answer it must produce.
  // Insert checks the slot against the count before the full check, so an insert past
  // the end of a full store reports out-of-range, not full.
  function automatic deque_answer_t apply_deque_op(logic [KIND_W-1:0] kind,
                                                   logic [VALUE_W-1:0] value,
                                                   logic [POS_W-1:0] position);
    deque_answer_t ans;
    int unsigned   slot;
    ans.read_data = '0;
    ans.status = ST_OK;
    slot = model_count;
    case (kind)
      KIND_APPEND, KIND_PREPEND, KIND_INSERT: begin
        if (kind == KIND_PREPEND) slot = 0;
        else if (kind == KIND_INSERT) slot = 32'(position);
        if (slot > model_count) begin
          ans.status = ST_RANGE;
        end else if (model_count >= STORE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          // everything from the slot upward moves up one place
          for (int i = model_count; i > slot; i--) model_elems[i] = model_elems[i-1];
          model_elems[slot] = value;
          model_count++;
        end
      end
      KIND_READ_IDX: begin
        if (position >= model_count) ans.status = ST_RANGE;
        else ans.read_data = model_elems[position];
      end
      KIND_READ_FIRST: begin
        if (model_count == 0) ans.status = ST_EMPTY;
        else ans.read_data = model_elems[0];
      end
      KIND_READ_LAST: begin
        if (model_count == 0) ans.status = ST_EMPTY;
        else ans.read_data = model_elems[model_count-1];
      end
      default: ;
    endcase
    ans.count = model_count[COUNT_W-1:0];
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Queue one item and track the count it leaves behind if it succeeds.
  task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                          input logic [POS_W-1:0] position);
    deque_op_t op;
    op.kind = kind;
    op.value = value;
    op.position = position;
    op_queue.push_back(op);
    if ((kind == KIND_APPEND || kind == KIND_PREPEND ||
         (kind == KIND_INSERT && position <= plan_count)) && plan_count < STORE_DEPTH)
      plan_count++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Random mix: mostly reads aimed inside the live range, a thin stream of writes so the
  // store fills slowly across all idling phases, plus spare kinds and raw noise.
  task automatic queue_random_op();
    int unsigned       pick;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    pick = $urandom_range(99);
    pos = POS_W'($urandom_range(127));
    if (pick < 5) begin
      case ($urandom_range(2))
        0: kind = KIND_APPEND;
        1: kind = KIND_PREPEND;
        default: begin
          kind = KIND_INSERT;
          if ($urandom_range(9) < 8) pos = POS_W'($urandom_range(plan_count));
        end
      endcase
    end else if (pick < 45) begin
      kind = KIND_READ_IDX;
      if (plan_count != 0 && $urandom_range(9) < 8)
        pos = POS_W'($urandom_range(plan_count - 1));
    end else if (pick < 65) begin
      kind = KIND_READ_FIRST;
    end else if (pick < 85) begin
      kind = KIND_READ_LAST;
    end else if (pick < 90) begin
      kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    end else begin
      kind = KIND_W'($urandom_range(7));
    end
    queue_op(kind, pick_value(), pos);
  endtask

  // Block until every queued item has transferred and every answer has come back.
  task automatic wait_drained();
    while (op_queue.size() != 0 || in_valid_i || awaited_answers.size() != 0)
      @(posedge clk_i);
  endtask

  // Sender: predict on each input transfer, then present the next item or idle.
  // A stalled item holds its payload and valid until it transfers.
  always @(posedge clk_i) begin : feed_blk
    deque_op_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        awaited_answers.push_back(apply_deque_op(kind_i, value_i, position_i));
      if (!in_valid_i || !in_stall_o) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = op_queue.pop_front();
          kind_i <= nxt.kind;
          value_i <= nxt.value;
          position_i <= nxt.position;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transfer against the oldest awaited answer, then
  // pick the stall for the next cycle.
  always @(posedge clk_i) begin : check_blk
    deque_answer_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("result with nothing awaited", read_data_o, '0);
        end else begin
          want = awaited_answers.pop_front();
          if (read_data_o !== want.read_data)
            report_mismatch("read_data", read_data_o, want.read_data);
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (count_o !== want.count)
            report_mismatch("count", count_o, want.count);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("indexed_deque_store_unit verification failed");
      $finish;
    end
  end

  initial begin : main_blk
    int send_tab[4] = '{0, 54, 0, 21};
    int recv_tab[4] = '{0, 0, 54, 21};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-store errors, insert past the end, spare kinds, then a small store
    // built with every write form and read back at its edges.
    queue_op(KIND_READ_IDX, 32'h0, 7'd0);            // indexed read of empty store
    queue_op(KIND_READ_FIRST, 32'h0, 7'd0);          // first of empty
    queue_op(KIND_READ_LAST, 32'h0, 7'd127);         // last of empty
    queue_op(KIND_INSERT, 32'h1234_5678, 7'd1);      // insert beyond count
    queue_op(KIND_INSERT, 32'hffff_ffff, 7'd127);    // insert far beyond count
    queue_op(KIND_SPARE_LO, 32'hdead_beef, 7'd5);
    queue_op(KIND_SPARE_HI, 32'hffff_ffff, 7'd127);
    queue_op(KIND_INSERT, 32'h7fff_ffff, 7'd0);      // insert at 0 acts as prepend
    queue_op(KIND_APPEND, 32'h8000_0000, 7'd0);
    queue_op(KIND_PREPEND, 32'h0000_0000, 7'd0);
    queue_op(KIND_INSERT, 32'hffff_ffff, 7'd3);      // insert at count acts as append
    queue_op(KIND_INSERT, 32'h5555_5555, 7'd2);      // middle insert, two elements move
    queue_op(KIND_INSERT, 32'haaaa_aaaa, 7'd1);
    queue_op(KIND_READ_FIRST, 32'h0, 7'd0);
    queue_op(KIND_READ_LAST, 32'h0, 7'd0);
    for (int p = 0; p < 6; p++) queue_op(KIND_READ_IDX, 32'h0, p[POS_W-1:0]);
    queue_op(KIND_READ_IDX, 32'h0, 7'd6);            // index equal to count
    queue_op(KIND_READ_IDX, 32'h0, 7'd64);
    queue_op(KIND_READ_IDX, 32'h0, 7'd127);
    wait_drained();

    // Random phases, one per idling profile; the store fills up along the way and the
    // late part runs against a full store.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_tab[ph];
      recv_stall_pct = recv_tab[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) queue_random_op();
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_answers.size() == 0) begin
      $display("indexed_deque_store_unit verification clean");
    end else begin
      $display("indexed_deque_store_unit verification failed");
    end
    $finish;
  end

endmodule
